[src/assert_macros.svh]
// Assertion macros used by the RTL file of the encoder's top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_PROP(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif

`endif

[src/uufe_pkg.sv]
// Types, constants and helper functions of the UTF-16 form encoder.
`default_nettype none

package uufe_pkg;

    localparam int UNIT_W = 16;
    localparam int CHAR_W = 7;
    localparam int MAX_BYTES = 6;
    localparam int CNT_W = 3;

    typedef logic [7:0] byte_t;
    typedef byte_t byte_arr_t [MAX_BYTES];
    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [1:0] {
        SUB_PCT,
        SUB_HI,
        SUB_LO
    } sub_t;

    localparam byte_t REPL_B0 = 8'hEF;
    localparam byte_t REPL_B1 = 8'hBF;
    localparam byte_t REPL_B2 = 8'hBD;

    localparam logic [CHAR_W-1:0] CH_PLUS = 7'h2B;
    localparam logic [CHAR_W-1:0] CH_PCT = 7'h25;
    localparam byte_t CH_SPACE = 8'h20;

    function automatic logic passes(input byte_t b);
        logic ok;
        ok = 1'b0;
        if (b inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39]}) begin
            ok = 1'b1;
        end
        if (b inside {8'h2D, 8'h5F, 8'h2E, 8'h21, 8'h7E, 8'h2A, 8'h28, 8'h29}) begin
            ok = 1'b1;
        end
        return ok;
    endfunction

    function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] n);
        logic [CHAR_W-1:0] c;
        if (n < 4'd10) begin
            c = 7'h30 + {3'b000, n};
        end
        else begin
            c = 7'h57 + {3'b000, n};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[src/utf16_url_form_encoder_top.sv]
// Top level of the UTF-16 to form-urlencoded ASCII encoder.
//
//   channel   dir   content
//   s_axis    in    tdata[15:0] code_unit
//   m_axis    out   tdata[6:0] out_char, tdata[7] zero; tlast last_of_run
//
// Each input word yields 0 to 18 output words, one per cycle from the emitter
// when the output does not stall. An input word is taken in the cycle its
// predecessor's last character moves out. Accepted bytes are registered in the
// work registers, and each character then in the output register.
// Reset clears the held surrogate and all valid flags.
// Output stalls hold the emitter and, through it, the input side.
`default_nettype none

`include "assert_macros.svh"

module utf16_url_form_encoder_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] code_unit
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [6:0] out_char, [7] zero
    output logic             m_axis_tlast    // last_of_run
);

    logic                      pend_valid_reg, pend_valid_next;
    logic [9:0]                pend_bits_reg, pend_bits_next;
    logic                      work_valid_reg, work_valid_next;
    uufe_pkg::byte_arr_t       bytes_reg, bytes_next;
    uufe_pkg::cnt_t            cnt_reg, cnt_next;
    uufe_pkg::cnt_t            bidx_reg, bidx_next;
    uufe_pkg::sub_t            sub_reg, sub_next;
    logic                      m_valid_reg, m_valid_next;
    logic [6:0]                m_char_reg, m_char_next;
    logic                      m_last_reg, m_last_next;

    logic                      accept;
    logic                      is_low, is_high, prefix, has_main;
    logic [20:0]               main_cp;
    uufe_pkg::byte_t           mb [4];
    uufe_pkg::cnt_t            main_len, new_cnt;
    uufe_pkg::byte_arr_t       new_bytes;

    uufe_pkg::byte_t           cur_byte;
    logic                      cur_space, cur_esc, sub_last, byte_last, move;
    logic [6:0]                cur_char;

    always_comb
    begin
        is_low  = s_axis_tdata inside {[16'hDC00:16'hDFFF]};
        is_high = s_axis_tdata inside {[16'hD800:16'hDBFF]};
        if (is_low) begin
            prefix   = 1'b0;
            has_main = 1'b1;
            main_cp  = pend_valid_reg
                     ? 21'h10000 + {1'b0, pend_bits_reg, s_axis_tdata[9:0]}
                     : 21'h00FFFD;
        end
        else begin
            prefix   = pend_valid_reg;
            has_main = !is_high && (s_axis_tdata != 16'h0000);
            main_cp  = {5'b00000, s_axis_tdata};
        end

        mb[1] = 8'h00;
        mb[2] = 8'h00;
        mb[3] = 8'h00;
        if (main_cp < 21'h80) begin
            main_len = 3'd1;
            mb[0] = {1'b0, main_cp[6:0]};
        end
        else if (main_cp < 21'h800) begin
            main_len = 3'd2;
            mb[0] = {3'b110, main_cp[10:6]};
            mb[1] = {2'b10, main_cp[5:0]};
        end
        else if (main_cp < 21'h10000) begin
            main_len = 3'd3;
            mb[0] = {4'b1110, main_cp[15:12]};
            mb[1] = {2'b10, main_cp[11:6]};
            mb[2] = {2'b10, main_cp[5:0]};
        end
        else begin
            main_len = 3'd4;
            mb[0] = {5'b11110, main_cp[20:18]};
            mb[1] = {2'b10, main_cp[17:12]};
            mb[2] = {2'b10, main_cp[11:6]};
            mb[3] = {2'b10, main_cp[5:0]};
        end

        if (prefix) begin
            new_bytes[0] = uufe_pkg::REPL_B0;
            new_bytes[1] = uufe_pkg::REPL_B1;
            new_bytes[2] = uufe_pkg::REPL_B2;
            new_bytes[3] = mb[0];
            new_bytes[4] = mb[1];
            new_bytes[5] = mb[2];
        end
        else begin
            new_bytes[0] = mb[0];
            new_bytes[1] = mb[1];
            new_bytes[2] = mb[2];
            new_bytes[3] = mb[3];
            new_bytes[4] = 8'h00;
            new_bytes[5] = 8'h00;
        end
        new_cnt = (prefix ? 3'd3 : 3'd0) + (has_main ? main_len : 3'd0);
    end

    always_comb
    begin
        cur_byte  = bytes_reg[bidx_reg];
        cur_space = (cur_byte == uufe_pkg::CH_SPACE);
        cur_esc   = !cur_space && !uufe_pkg::passes(cur_byte);
        if (cur_space) begin
            cur_char = uufe_pkg::CH_PLUS;
        end
        else if (!cur_esc) begin
            cur_char = cur_byte[6:0];
        end
        else begin
            case (sub_reg)
                uufe_pkg::SUB_PCT: cur_char = uufe_pkg::CH_PCT;
                uufe_pkg::SUB_HI:  cur_char = uufe_pkg::hex_char(cur_byte[7:4]);
                uufe_pkg::SUB_LO:  cur_char = uufe_pkg::hex_char(cur_byte[3:0]);
                default:           cur_char = uufe_pkg::CH_PCT;
            endcase
        end
        sub_last  = !cur_esc || (sub_reg == uufe_pkg::SUB_LO);
        byte_last = ((bidx_reg + 3'd1) == cnt_reg);
        move      = work_valid_reg && (!m_valid_reg || m_axis_tready);
    end

    assign s_axis_tready = !work_valid_reg || (move && sub_last && byte_last);
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_bits_next  = pend_bits_reg;
        work_valid_next = work_valid_reg;
        bytes_next      = bytes_reg;
        cnt_next        = cnt_reg;
        bidx_next       = bidx_reg;
        sub_next        = sub_reg;
        m_valid_next    = m_valid_reg;
        m_char_next     = m_char_reg;
        m_last_next     = m_last_reg;

        if (move) begin
            m_valid_next = 1'b1;
            m_char_next  = cur_char;
            m_last_next  = sub_last && byte_last;
            if (sub_last) begin
                sub_next = uufe_pkg::SUB_PCT;
                if (byte_last) begin
                    work_valid_next = 1'b0;
                end
                else begin
                    bidx_next = bidx_reg + 3'd1;
                end
            end
            else begin
                sub_next = (sub_reg == uufe_pkg::SUB_PCT) ? uufe_pkg::SUB_HI
                                                          : uufe_pkg::SUB_LO;
            end
        end
        else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        if (accept) begin
            pend_valid_next = is_high;
            pend_bits_next  = is_high ? s_axis_tdata[9:0] : 10'd0;
            if (new_cnt != 3'd0) begin
                work_valid_next = 1'b1;
                bytes_next      = new_bytes;
                cnt_next        = new_cnt;
                bidx_next       = 3'd0;
                sub_next        = uufe_pkg::SUB_PCT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pend_valid_reg <= 1'b0;
            pend_bits_reg  <= 10'd0;
            work_valid_reg <= 1'b0;
            bidx_reg       <= 3'd0;
            sub_reg        <= uufe_pkg::SUB_PCT;
            m_valid_reg    <= 1'b0;
        end
        else begin
            pend_valid_reg <= pend_valid_next;
            pend_bits_reg  <= pend_bits_next;
            work_valid_reg <= work_valid_next;
            bidx_reg       <= bidx_next;
            sub_reg        <= sub_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg  <= bytes_next;
        cnt_reg    <= cnt_next;
        m_char_reg <= m_char_next;
        m_last_reg <= m_last_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {1'b0, m_char_reg};
    assign m_axis_tlast  = m_last_reg;

    `ASSERT_PROP(a_work_count, clk, rst_n,
        work_valid_reg |-> (cnt_reg != 3'd0) && (bidx_reg < cnt_reg) && (cnt_reg <= 3'd6))
    `ASSERT_NEVER(a_sub_only_escaped, clk, rst_n,
        (sub_reg != uufe_pkg::SUB_PCT) && !(work_valid_reg && cur_esc))
    `ASSERT_PROP(a_high_held, clk, rst_n,
        (accept && is_high) |=> pend_valid_reg)
    `ASSERT_PROP(a_pend_from_input, clk, rst_n,
        $rose(pend_valid_reg) |-> $past(accept))

endmodule

`default_nettype wire

[tb/sv/utf16_url_form_encoder_top_test.sv]
// Self-checking testbench for the UTF-16 to form-urlencoded encoder top level.
`default_nettype none

module utf16_url_form_encoder_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_UNITS = 71;
    localparam int DRAIN_CYCLES = 8;
    localparam int NUM_ROWS = 25;

    localparam logic [15:0] HIGH_SURR_FIRST = 16'hD800;
    localparam logic [15:0] HIGH_SURR_LAST = 16'hDBFF;
    localparam logic [15:0] LOW_SURR_FIRST = 16'hDC00;
    localparam logic [15:0] LOW_SURR_LAST = 16'hDFFF;
    localparam logic [15:0] END_OF_STRING = 16'h0000;
    localparam logic [20:0] REPLACEMENT_CP = 21'h00FFFD;

    typedef struct packed {
        logic [uufe_pkg::CHAR_W-1:0] ch;
        logic last;
    } form_char_t;

    typedef struct {
        logic [15:0] code;
        bit typed;
        string text;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic [15:0] s_axis_tdata = 16'h0000;
    logic m_axis_tready = 1'b0;
    wire logic s_axis_tready;
    wire logic m_axis_tvalid;
    wire logic [7:0] m_axis_tdata;
    wire logic m_axis_tlast;

    logic [9:0] held_bits = 10'd0;
    logic held_valid = 1'b0;
    logic [uufe_pkg::CHAR_W-1:0] run_chars[$];
    form_char_t pending_chars[$];

    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_req = 0;
    int hold_ack = 0;
    int hold_left = 0;
    int cycle_cnt = 0;
    int units_sent = 0;
    int chars_checked = 0;
    int mismatches = 0;

    stim_row_t stim_rows [NUM_ROWS] = '{
        '{16'h0041, 1'b1, "A"},
        '{16'h0000, 1'b1, ""},
        '{16'h0020, 1'b1, "+"},
        '{16'h007E, 1'b1, "~"},
        '{16'h002A, 1'b1, "*"},
        '{16'h002B, 1'b1, "%2b"},
        '{16'h0001, 1'b1, "%01"},
        '{16'h007F, 1'b1, "%7f"},
        '{16'h0080, 1'b1, "%c2%80"},
        '{16'h07FF, 1'b1, "%df%bf"},
        '{16'h0800, 1'b1, "%e0%a0%80"},
        '{16'hFFFF, 1'b1, "%ef%bf%bf"},
        '{16'hD800, 1'b1, ""},
        '{16'hDC00, 1'b1, "%f0%90%80%80"},
        '{16'hDBFF, 1'b1, ""},
        '{16'hDFFF, 1'b1, "%f4%8f%bf%bf"},
        '{16'hDC00, 1'b1, "%ef%bf%bd"},
        '{16'hD801, 1'b1, ""},
        '{16'hD802, 1'b1, "%ef%bf%bd"},
        '{16'h0061, 1'b1, "%ef%bf%bda"},
        '{16'hDA00, 1'b1, ""},
        '{16'h0000, 1'b1, "%ef%bf%bd"},
        '{16'hD800, 1'b1, ""},
        '{16'hFFFF, 1'b1, "%ef%bf%bd%ef%bf%bf"},
        '{16'h4E2D, 1'b0, ""}
    };

    utf16_url_form_encoder_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit is_unreserved(input logic [7:0] b);
        return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") ||
               (b >= "0" && b <= "9") || b == "-" || b == "_" || b == "." ||
               b == "!" || b == "~" || b == "*" || b == "(" || b == ")";
    endfunction

    function automatic logic [6:0] hex_digit(input logic [3:0] nib);
        return (nib < 4'd10) ? (7'h30 + nib) : (7'h61 + (nib - 4'd10));
    endfunction

    function void add_char(input logic [uufe_pkg::CHAR_W-1:0] c);
        run_chars = {run_chars, c};
    endfunction

    function void form_byte(input logic [7:0] b);
        if (b == " ")
        begin
            add_char(7'h2B);
        end
        else if (is_unreserved(b))
        begin
            add_char(b[6:0]);
        end
        else
        begin
            add_char(7'h25);
            add_char(hex_digit(b[7:4]));
            add_char(hex_digit(b[3:0]));
        end
    endfunction

    function void form_code_point(input logic [20:0] cp);
        if (cp < 21'h80)
        begin
            form_byte(cp[7:0]);
        end
        else if (cp < 21'h800)
        begin
            form_byte({3'b110, cp[10:6]});
            form_byte({2'b10, cp[5:0]});
        end
        else if (cp < 21'h10000)
        begin
            form_byte({4'b1110, cp[15:12]});
            form_byte({2'b10, cp[11:6]});
            form_byte({2'b10, cp[5:0]});
        end
        else
        begin
            form_byte({5'b11110, cp[20:18]});
            form_byte({2'b10, cp[17:12]});
            form_byte({2'b10, cp[11:6]});
            form_byte({2'b10, cp[5:0]});
        end
    endfunction

    // Works out the characters one code unit yields and updates the held surrogate.
    function void encode_unit(input logic [15:0] u);
        run_chars.delete();
        if (u >= LOW_SURR_FIRST && u <= LOW_SURR_LAST)
        begin
            if (held_valid)
            begin
                form_code_point(21'h10000 + {1'b0, held_bits, u[9:0]});
            end
            else
            begin
                form_code_point(REPLACEMENT_CP);
            end
            held_valid = 1'b0;
            held_bits = 10'd0;
        end
        else
        begin
            if (held_valid)
            begin
                form_code_point(REPLACEMENT_CP);
            end
            held_valid = 1'b0;
            held_bits = 10'd0;
            if (u >= HIGH_SURR_FIRST && u <= HIGH_SURR_LAST)
            begin
                held_valid = 1'b1;
                held_bits = u[9:0];
            end
            else if (u != END_OF_STRING)
            begin
                form_code_point({5'd0, u});
            end
        end
    endfunction

    task automatic send_unit(input logic [15:0] u, input bit typed, input string text);
        int gap;
        int k;
        form_char_t fc;
        logic [7:0] tc;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= u;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        encode_unit(u);
        if (typed)
        begin
            run_chars.delete();
            for (k = 0; k < text.len(); k++)
            begin
                tc = text[k];
                add_char(tc[6:0]);
            end
        end
        for (k = 0; k < run_chars.size(); k++)
        begin
            fc.ch = run_chars[k];
            fc.last = (k == run_chars.size() - 1);
            pending_chars = {pending_chars, fc};
        end
        units_sent++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_chars.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_random();
        int pick;
        logic [15:0] u;
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            send_unit(16'($urandom_range(16'h20, 16'h7E)), 1'b0, "");
        end
        else if (pick < 40)
        begin
            send_unit(16'($urandom_range(16'h01, 16'h7F)), 1'b0, "");
        end
        else if (pick < 52)
        begin
            send_unit(16'($urandom_range(16'h80, 16'h7FF)), 1'b0, "");
        end
        else if (pick < 67)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                u = 16'($urandom_range(16'h800, 16'hD7FF));
            end
            else
            begin
                u = 16'($urandom_range(16'hE000, 16'hFFFF));
            end
            send_unit(u, 1'b0, "");
        end
        else if (pick < 85)
        begin
            send_unit(16'($urandom_range(HIGH_SURR_FIRST, HIGH_SURR_LAST)), 1'b0, "");
            send_unit(16'($urandom_range(LOW_SURR_FIRST, LOW_SURR_LAST)), 1'b0, "");
        end
        else if (pick < 92)
        begin
            send_unit(16'($urandom_range(HIGH_SURR_FIRST, LOW_SURR_LAST)), 1'b0, "");
        end
        else if (pick < 96)
        begin
            send_unit(END_OF_STRING, 1'b0, "");
        end
        else
        begin
            send_unit(16'($urandom_range(0, 16'hFFFF)), 1'b0, "");
        end
    endtask

    always @(posedge clk)
    begin
        if (hold_req != hold_ack)
        begin
            hold_ack <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        form_char_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_chars.size() == 0)
            begin
                mismatches++;
                $display("%0t: word with none expected: expected nothing, actual %h last %b",
                         $time, m_axis_tdata, m_axis_tlast);
            end
            else
            begin
                want = pending_chars.pop_front();
                chars_checked++;
                if (m_axis_tdata !== {1'b0, want.ch})
                begin
                    mismatches++;
                    $display("%0t: character mismatch: expected %h, actual %h",
                             $time, {1'b0, want.ch}, m_axis_tdata);
                end
                if (m_axis_tlast !== want.last)
                begin
                    mismatches++;
                    $display("%0t: last-of-run mismatch: expected %b, actual %b",
                             $time, want.last, m_axis_tlast);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d characters outstanding.",
                     cycle_cnt, pending_chars.size());
            $display("utf16_url_form_encoder_top_test NOT OK");
            $finish;
        end
    end

    initial
    begin
        int i;
        int phase;
        int n;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        for (i = 0; i < NUM_ROWS; i++)
        begin
            send_unit(stim_rows[i].code, stim_rows[i].typed, stim_rows[i].text);
        end
        drain_results();

        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 53;
                    stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct = 53;
                end
                default:
                begin
                    send_idle_pct = 26;
                    stall_pct = 26;
                end
            endcase
            n = 0;
            while (n < PHASE_UNITS)
            begin
                if (phase == 0 && n == 20)
                begin
                    hold_req <= hold_req + 1;
                end
                send_random();
                n++;
            end
            drain_results();
        end

        $display("Encoded %0d code units (%0d from the directed table)",
                 units_sent, NUM_ROWS);
        $display("into %0d checked characters over four pacing phases and one long hold-off.",
                 chars_checked);
        if (mismatches == 0 && pending_chars.size() == 0)
        begin
            $display("utf16_url_form_encoder_top_test OK");
        end
        else
        begin
            $display("utf16_url_form_encoder_top_test NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire
